FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the display aspect ratio reducer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define DARR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during and straight after reset.
`define DARR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/darr_pkg.sv
// ----------------------------------------------------------------------------
// darr_pkg
// Shared constants and the command and status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package darr_pkg;

   // Default width of each input dimension field.
   localparam int DIM_BITS_DEFAULT = 16;

   // Width of each reduced aspect term on the result side.
   localparam int OUT_BITS = 32;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the input beat
      logic mul;       // form the two aspect products
      logic gcd_init;  // seed the divisor search
      logic gcd_step;  // one binary gcd iteration
      logic div_init;  // latch the divisor and clear remainders
      logic div_step;  // one restoring division bit on both terms
      logic out_load;  // move the quotients into the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic gcd_equal; // both gcd operands match, search finished
      logic div_last;  // the final division bit is being formed
   } status_type;

endpackage

FILE: hw/rtl/darr_ctrl.sv
// ----------------------------------------------------------------------------
// darr_ctrl
// Sequencer for the aspect ratio reducer: steps one item through the
// product, gcd and division phases and owns both handshakes.
// ----------------------------------------------------------------------------
module darr_ctrl
   import darr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_GINIT = 6'b000100,
      ST_GCD   = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new value when empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_GINIT;
         end
         ST_GINIT: begin
            cmd.gcd_init = 1'b1;
            state_in     = ST_GCD;
         end
         ST_GCD: begin
            if (status.gcd_equal) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag: set on load, cleared once the beat is taken.
   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/darr_datapath.sv
// ----------------------------------------------------------------------------
// darr_datapath
// Product multipliers, a binary gcd unit and a pair of bit-serial
// restoring dividers sharing one divisor, plus the result register.
// ----------------------------------------------------------------------------
module darr_datapath
   import darr_pkg::*;
#(
   parameter int DIM_BITS = DIM_BITS_DEFAULT
)
(
   input  logic                clock,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [DIM_BITS-1:0] frame_width,
   input  logic [DIM_BITS-1:0] frame_height,
   input  logic [DIM_BITS-1:0] sar_num,
   input  logic [DIM_BITS-1:0] sar_den,
   output logic [OUT_BITS-1:0] dar_width,
   output logic [OUT_BITS-1:0] dar_height
);

   localparam int WP = 2 * DIM_BITS;
   localparam int KW = $clog2(WP);
   localparam int CW = $clog2(WP + 1);
   localparam int XW = (WP > OUT_BITS) ? WP : OUT_BITS;

   logic [DIM_BITS-1:0] w_ff, h_ff, n_ff, d_ff;
   logic [DIM_BITS-1:0] w_in, h_in, n_in, d_in;
   logic [WP-1:0]       hx_ff, vx_ff, hx_in, vx_in;
   logic [WP-1:0]       a_ff, b_ff, a_in, b_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [WP-1:0]       g_ff, g_in;
   logic [WP-1:0]       rh_ff, rv_ff, rh_in, rv_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [OUT_BITS-1:0] dw_ff, dh_ff, dw_in, dh_in;

   logic [WP-1:0]       mul_h, mul_v;
   logic                sar_equal;
   logic                zero_term;
   logic [WP-1:0]       diff_ab, diff_ba;
   logic [WP:0]         trial_h, trial_v, sub_h, sub_v;
   logic                ge_h, ge_v;
   logic [XW-1:0]       q_h, q_v;

   // Aspect products; equal sample terms leave width and height as they are.
   assign sar_equal = (n_ff == d_ff);
   assign mul_h     = WP'(w_ff) * WP'(n_ff);
   assign mul_v     = WP'(h_ff) * WP'(d_ff);

   // A zero term makes the divisor one.
   assign zero_term = (hx_ff == '0) || (vx_ff == '0);

   assign diff_ab = a_ff - b_ff;
   assign diff_ba = b_ff - a_ff;

   // One restoring division bit for each term against the common divisor.
   assign trial_h = {rh_ff, hx_ff[WP-1]};
   assign trial_v = {rv_ff, vx_ff[WP-1]};
   assign sub_h   = trial_h - {1'b0, g_ff};
   assign sub_v   = trial_v - {1'b0, g_ff};
   assign ge_h    = !sub_h[WP];
   assign ge_v    = !sub_v[WP];

   // Quotients keep their low result bits only.
   assign q_h = XW'(hx_ff);
   assign q_v = XW'(vx_ff);

   assign status.gcd_equal = (a_ff == b_ff);
   assign status.div_last  = (cnt_ff == CW'(1));

   // Input capture.
   always_comb begin
      w_in = w_ff;
      h_in = h_ff;
      n_in = n_ff;
      d_in = d_ff;
      if (cmd.load) begin
         w_in = frame_width;
         h_in = frame_height;
         n_in = sar_num;
         d_in = sar_den;
      end
   end

   // Product, then dividend and quotient shift registers.
   always_comb begin
      hx_in = hx_ff;
      vx_in = vx_ff;
      rh_in = rh_ff;
      rv_in = rv_ff;
      priority if (cmd.mul) begin
         hx_in = sar_equal ? WP'(w_ff) : mul_h;
         vx_in = sar_equal ? WP'(h_ff) : mul_v;
      end else if (cmd.div_init) begin
         rh_in = '0;
         rv_in = '0;
      end else if (cmd.div_step) begin
         rh_in = ge_h ? sub_h[WP-1:0] : trial_h[WP-1:0];
         rv_in = ge_v ? sub_v[WP-1:0] : trial_v[WP-1:0];
         hx_in = {hx_ff[WP-2:0], ge_h};
         vx_in = {vx_ff[WP-2:0], ge_v};
      end else begin
         hx_in = hx_ff;
      end
   end

   // Binary gcd: strip common twos into k, then halve or subtract odd terms.
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      k_in = k_ff;
      priority if (cmd.gcd_init) begin
         a_in = zero_term ? WP'(1) : hx_ff;
         b_in = zero_term ? WP'(1) : vx_ff;
         k_in = '0;
      end else if (cmd.gcd_step) begin
         priority if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + KW'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_in = diff_ab >> 1;
         end else begin
            b_in = diff_ba >> 1;
         end
      end else begin
         a_in = a_ff;
      end
   end

   // Divisor and bit counter.
   always_comb begin
      g_in   = g_ff;
      cnt_in = cnt_ff;
      priority if (cmd.div_init) begin
         g_in   = a_ff << k_ff;
         cnt_in = CW'(WP);
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff - CW'(1);
      end else begin
         g_in = g_ff;
      end
   end

   // Result register.
   always_comb begin
      dw_in = dw_ff;
      dh_in = dh_ff;
      if (cmd.out_load) begin
         dw_in = q_h[OUT_BITS-1:0];
         dh_in = q_v[OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      h_ff   <= h_in;
      n_ff   <= n_in;
      d_ff   <= d_in;
      hx_ff  <= hx_in;
      vx_ff  <= vx_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      k_ff   <= k_in;
      g_ff   <= g_in;
      rh_ff  <= rh_in;
      rv_ff  <= rv_in;
      cnt_ff <= cnt_in;
      dw_ff  <= dw_in;
      dh_ff  <= dh_in;
   end

   assign dar_width  = dw_ff;
   assign dar_height = dh_ff;

endmodule

FILE: hw/rtl/display_aspect_ratio_reducer_core.sv
// Flow: an accepted request is captured, its products formed, the gcd unit
// seeded and iterated, then the bit-serial divider reduces both terms and the
// result is loaded. One item at a time; the next request can be taken in the
// cycle after the result is loaded, which waits while an older result is held.
// The gcd loop works one bit a cycle. Reset is synchronous and active high;
// it empties the sequencer and the result register, data registers keep.
// ----------------------------------------------------------------------------
// display_aspect_ratio_reducer_core
// Reduces a display aspect ratio, formed from frame size and sample aspect,
// by its greatest common divisor.
// ----------------------------------------------------------------------------
module display_aspect_ratio_reducer_core
   import darr_pkg::*;
#(
   parameter int DIM_BITS = DIM_BITS_DEFAULT
)
(
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // frame_width, frame_height, sar_num, sar_den, then zero padding
   input  logic [((4*DIM_BITS+7)/8)*8-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // dar_width, dar_height
   output logic [2*OUT_BITS-1:0]                rsp_tdata
);

   cmd_type             cmd;
   status_type          status;
   logic [OUT_BITS-1:0] dar_width, dar_height;

   // Sequencer.
   darr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // Arithmetic.
   darr_datapath #(
      .DIM_BITS (DIM_BITS)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .status       (status),
      .frame_width  (req_tdata[DIM_BITS-1:0]),
      .frame_height (req_tdata[2*DIM_BITS-1:DIM_BITS]),
      .sar_num      (req_tdata[3*DIM_BITS-1:2*DIM_BITS]),
      .sar_den      (req_tdata[4*DIM_BITS-1:3*DIM_BITS]),
      .dar_width    (dar_width),
      .dar_height   (dar_height)
   );

   assign rsp_tdata = {dar_height, dar_width};

endmodule

FILE: hw/rtl/darr_checker.sv
// ----------------------------------------------------------------------------
// darr_checker
// Port-level checks on the aspect ratio reducer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module darr_checker
   import darr_pkg::*;
#(
   parameter int DIM_BITS = DIM_BITS_DEFAULT
)
(
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [((4*DIM_BITS+7)/8)*8-1:0]  req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [2*OUT_BITS-1:0]            rsp_tdata
);

   logic req_beat;

   assign req_beat = req_tvalid && req_tready;

   // The result register is empty after reset.
   `DARR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")

   // A stalled request beat holds its value.
   `DARR_ASSERT(a_req_hold, clock, reset, req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata), "stalled request changed")

   // A stalled result beat holds its value.
   `DARR_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // Only one item is in work: a taken request closes the input side.
   `DARR_ASSERT(a_one_item, clock, reset, req_beat |=> !req_tready, "request taken while busy")

   // A result cannot appear while the sequencer is still in its product and gcd seed states.
   `DARR_ASSERT(a_min_latency, clock, reset, req_beat |=> !$rose(rsp_tvalid) ##1 !$rose(rsp_tvalid), "result too early")

endmodule

bind display_aspect_ratio_reducer_core darr_checker #(
   .DIM_BITS (DIM_BITS)
) u_darr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
